// ===== rtl/lzss_pkg.sv =====
// Shared types and constants of the LZSS stream decompressor.
package lzss_pkg;

  localparam int HISTORY_DEPTH    = 8192;
  localparam int HIST_AW          = $clog2(HISTORY_DEPTH);
  localparam int MAX_HEADER_BYTES = 9;
  localparam int LEN_W            = 63;
  localparam int OFF_W            = 13;
  localparam int CNT_W            = 5;
  localparam int SHIFT_W          = 4;
  localparam int HDR_DIGITS       = 9;

  localparam logic [OFF_W-1:0] OFF_BIAS = OFF_W'(3);
  localparam logic [CNT_W-1:0] LEN_BIAS = CNT_W'(3);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       data_end;
    logic       bad_reference;
  } out_item_t;

endpackage

// ===== rtl/lzss_stream_decompressor.sv =====
// LZSS stream decompressor: header/flag parser, match copy sequencer, history RAM.
// Order: a literal byte appears in the cycle after its request is accepted; for a match,
//   the copy phase issues its first history read once the output slot is free, and the
//   byte passes through the RAM read register into the slot. Copies give one byte per cycle
//   while dst_ready holds; a match of 3..18 bytes holds the input until its copy ends.
// Reset: synchronous, clears the parser and output valid; the history RAM is not cleared.
module lzss_stream_decompressor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  lzss_pkg::in_item_t   src_item,
  output logic                 dst_valid,
  input  logic                 dst_ready,
  output lzss_pkg::out_item_t  dst_item
);
  import lzss_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_TOKEN,
    PH_MATCH,
    PH_COPY,
    PH_DONE
  } phase_t;

  localparam logic [HIST_AW:0] DEPTH_X = (HIST_AW+1)'(HISTORY_DEPTH);
  localparam logic [HIST_AW-1:0] LAST_ADDR = HIST_AW'(HISTORY_DEPTH - 1);

  // Parser and copy state
  phase_t              phase;
  logic [LEN_W-1:0]    total_length;
  logic [SHIFT_W-1:0]  header_shift;
  logic [7:0]          flag_bits;
  logic [3:0]          flags_left;
  logic [7:0]          match_first_byte;
  logic [LEN_W-1:0]    produced_count;
  logic [HIST_AW-1:0]  wr_ptr;
  logic [HIST_AW-1:0]  rd_ptr;
  logic [OFF_W-1:0]    copy_off;
  logic [CNT_W-1:0]    copy_left;

  // Output slot
  logic                out_valid;
  logic                slot_fresh;
  logic                slot_from_ram;
  logic                slot_bad;
  logic                slot_last;
  logic                slot_end;
  logic [7:0]          slot_lit;
  logic [HIST_AW-1:0]  slot_waddr;

  // RAM port signals
  logic                ram_we;
  logic                ram_re;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_q;

  // Request decode
  logic                src_take;
  logic                issue;
  phase_t              phase_eff;
  logic [7:0]          b;
  logic [LEN_W-1:0]    total_eff;
  logic [SHIFT_W-1:0]  shift_eff;
  logic [LEN_W-1:0]    hdr_add;
  logic [LEN_W-1:0]    hdr_total;
  logic [SHIFT_W-1:0]  hdr_count;
  logic                hdr_end;
  logic [LEN_W-1:0]    pc_inc;
  logic                done_now;
  logic [3:0]          fl_dec;
  phase_t              tok_phase;
  logic [OFF_W-1:0]    match_off;
  logic [HIST_AW:0]    rd_start;
  logic                copy_bad;
  logic [HIST_AW-1:0]  wr_ptr_inc;
  logic [HIST_AW-1:0]  rd_ptr_inc;

  assign b         = src_item.in_byte;
  assign src_ready = (phase != PH_COPY) && (!out_valid || dst_ready);
  assign src_take  = src_valid && src_ready;
  assign issue     = (phase == PH_COPY) && (!out_valid || dst_ready);
  assign phase_eff = src_item.stream_start ? PH_HEADER : phase;
  assign total_eff = src_item.stream_start ? '0 : total_length;
  assign shift_eff = src_item.stream_start ? '0 : header_shift;

  // Place seven header value bits at their digit position
  always_comb begin
    hdr_add = '0;
    if (shift_eff < SHIFT_W'(HDR_DIGITS)) begin
      hdr_add = LEN_W'(b[6:0]) << (7 * shift_eff);
    end
  end
  assign hdr_total = total_eff | hdr_add;
  assign hdr_count = shift_eff + 1'b1;
  assign hdr_end   = !b[7] || (hdr_count >= SHIFT_W'(MAX_HEADER_BYTES));

  // Byte count and end of token
  assign pc_inc    = produced_count + 1'b1;
  assign done_now  = (pc_inc == total_length);
  assign fl_dec    = flags_left - 1'b1;
  assign tok_phase = done_now ? PH_DONE : ((fl_dec == '0) ? PH_FLAG : PH_TOKEN);

  // Match offset and start of the copy in the ring
  assign match_off = {1'b0, match_first_byte[3:0], b} + OFF_BIAS;
  always_comb begin
    if ({1'b0, wr_ptr} >= (HIST_AW+1)'(match_off)) begin
      rd_start = {1'b0, wr_ptr} - (HIST_AW+1)'(match_off);
    end else begin
      rd_start = {1'b0, wr_ptr} + DEPTH_X - (HIST_AW+1)'(match_off);
    end
  end
  assign copy_bad = ((produced_count >> OFF_W) == '0) &&
                    (produced_count[OFF_W-1:0] < copy_off);

  assign wr_ptr_inc = (wr_ptr == LAST_ADDR) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == LAST_ADDR) ? '0 : rd_ptr + 1'b1;

  // Parser, copy sequencer and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      total_length     <= '0;
      header_shift     <= '0;
      flag_bits        <= '0;
      flags_left       <= '0;
      match_first_byte <= '0;
      produced_count   <= '0;
      wr_ptr           <= '0;
      out_valid        <= 1'b0;
      slot_fresh       <= 1'b0;
    end else begin
      slot_fresh <= 1'b0;
      if (out_valid && dst_ready) begin
        out_valid <= 1'b0;
      end
      if (src_take) begin
        unique case (phase_eff)
          PH_HEADER: begin
            total_length   <= hdr_total;
            header_shift   <= hdr_count;
            produced_count <= '0;
            wr_ptr         <= '0;
            if (hdr_end) begin
              phase <= (hdr_total == '0) ? PH_DONE : PH_FLAG;
            end else begin
              phase <= PH_HEADER;
            end
          end
          PH_FLAG: begin
            flag_bits  <= b;
            flags_left <= 4'd8;
            phase      <= PH_TOKEN;
          end
          PH_TOKEN: begin
            if (flag_bits[7]) begin
              // Emit a literal into the slot
              out_valid      <= 1'b1;
              slot_fresh     <= 1'b1;
              slot_from_ram  <= 1'b0;
              slot_bad       <= 1'b0;
              slot_last      <= 1'b1;
              slot_end       <= done_now;
              slot_lit       <= b;
              slot_waddr     <= wr_ptr;
              produced_count <= pc_inc;
              wr_ptr         <= wr_ptr_inc;
              flag_bits      <= {flag_bits[6:0], 1'b0};
              flags_left     <= fl_dec;
              phase          <= tok_phase;
            end else begin
              match_first_byte <= b;
              phase            <= PH_MATCH;
            end
          end
          PH_MATCH: begin
            copy_off  <= match_off;
            copy_left <= CNT_W'(match_first_byte[7:4]) + LEN_BIAS;
            rd_ptr    <= rd_start[HIST_AW-1:0];
            phase     <= PH_COPY;
          end
          PH_DONE: begin
            phase <= PH_DONE;
          end
          default: begin
            phase <= PH_DONE;
          end
        endcase
      end else if (issue) begin
        // Advance one copied byte; its data arrives in the RAM read register
        out_valid      <= 1'b1;
        slot_fresh     <= 1'b1;
        slot_from_ram  <= 1'b1;
        slot_bad       <= copy_bad;
        slot_last      <= (copy_left == CNT_W'(1)) || done_now;
        slot_end       <= done_now;
        slot_waddr     <= wr_ptr;
        produced_count <= pc_inc;
        wr_ptr         <= wr_ptr_inc;
        rd_ptr         <= rd_ptr_inc;
        copy_left      <= copy_left - 1'b1;
        if ((copy_left == CNT_W'(1)) || done_now) begin
          flag_bits  <= {flag_bits[6:0], 1'b0};
          flags_left <= fl_dec;
          phase      <= tok_phase;
        end
      end
    end
  end

  // Write each emitted byte to the history once, the cycle it lands in the slot
  assign ram_re    = issue;
  assign ram_we    = slot_fresh;
  assign ram_wdata = slot_bad ? 8'h00 : (slot_from_ram ? ram_q : slot_lit);

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_q)
  );

  assign dst_valid              = out_valid;
  assign dst_item.out_byte      = ram_wdata;
  assign dst_item.run_last      = slot_last;
  assign dst_item.data_end      = slot_end;
  assign dst_item.bad_reference = slot_bad;

  // The end of the declared length always closes the run of its request
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_item.data_end) |-> dst_item.run_last)
    else $error("data_end without run_last");

  // Once the last byte is delivered the parser ignores the stream
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_ready && dst_item.data_end) |-> (phase == PH_DONE))
    else $error("parser not done after data_end");

  // A copy read never hits the entry being written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_re && ram_we) |-> (rd_ptr != slot_waddr))
    else $error("history read and write collide");

  // Never produce beyond the declared length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    produced_count <= total_length)
    else $error("produced count passed declared length");

endmodule

// ===== rtl/lzss_ram.sv =====
// Generic simple dual-port RAM with registered, enabled read.
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry; hold read data when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== bench/lzss_stream_decompressor_check.sv =====
// Checker for the LZSS stream decompressor: decodes accepted requests and compares results.
module lzss_stream_decompressor_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  input  logic                src_ready,
  input  lzss_pkg::in_item_t  src_item,
  input  logic                dst_valid,
  input  logic                dst_ready,
  input  lzss_pkg::out_item_t dst_item,
  output int                  errors,
  output int                  pending,
  output int                  results_seen,
  output int                  bad_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import lzss_pkg::*;

  typedef enum logic [2:0] {
    READ_HEADER,
    READ_FLAG,
    READ_TOKEN,
    READ_MATCH,
    STREAM_DONE
  } phase_t;

  // Decoder state, kept alongside the block
  phase_t             phase;
  logic [LEN_W-1:0]   total_len;
  logic [LEN_W-1:0]   produced;
  logic [SHIFT_W-1:0] hdr_count;
  logic [7:0]         flag_bits;
  logic [3:0]         flags_left;
  logic [7:0]         match_first;
  logic [7:0]         window [HISTORY_DEPTH];

  // Bytes decoded from one request, then the queue of bytes still due
  out_item_t run_buf [18];
  int        run_len;
  out_item_t expected_out [$];
  out_item_t head;

  function automatic void clear_stream();
    phase       = READ_HEADER;
    total_len   = '0;
    produced    = '0;
    hdr_count   = '0;
    flag_bits   = '0;
    flags_left  = '0;
    match_first = '0;
  endfunction

  // Append one decoded byte to the window and the run; report end of data
  function automatic logic put_byte(input logic [7:0] v, input logic bad);
    out_item_t r;
    window[HIST_AW'(produced)] = v;
    produced = produced + 1'b1;
    r.out_byte      = v;
    r.run_last      = 1'b0;
    r.data_end      = (produced == total_len);
    r.bad_reference = bad;
    run_buf[run_len] = r;
    run_len++;
    return produced == total_len;
  endfunction

  // Advance to the next token, flag byte or the end of data
  function automatic void next_token(input logic done);
    flag_bits = flag_bits << 1;
    if (flags_left != 0) flags_left--;
    if (done) phase = STREAM_DONE;
    else if (flags_left == 0) phase = READ_FLAG;
    else phase = READ_TOKEN;
  endfunction

  task automatic decode_request(input logic [7:0] b, input logic start);
    logic        done;
    logic        bad;
    logic [7:0]  v;
    logic [4:0]  len;
    logic [12:0] off;
    int          pos;
    run_len = 0;
    done = 1'b0;
    if (start) clear_stream();
    case (phase)
      READ_HEADER: begin
        pos = 7 * int'(hdr_count);
        if (pos < LEN_W) total_len = total_len + (LEN_W'(b[6:0]) << pos);
        hdr_count++;
        if (!b[7] || hdr_count >= MAX_HEADER_BYTES)
          phase = (total_len == 0) ? STREAM_DONE : READ_FLAG;
      end
      READ_FLAG: begin
        flag_bits  = b;
        flags_left = 4'd8;
        phase      = READ_TOKEN;
      end
      READ_TOKEN: begin
        if (flag_bits[7]) begin
          next_token(put_byte(b, 1'b0));
        end else begin
          match_first = b;
          phase       = READ_MATCH;
        end
      end
      READ_MATCH: begin
        len = 5'(match_first[7:4]) + LEN_BIAS;
        off = {1'b0, match_first[3:0], b} + OFF_BIAS;
        // Copy until the length runs out or the declared size is reached
        for (int k = 0; k < int'(len) && !done; k++) begin
          bad  = LEN_W'(off) > produced;
          v    = bad ? 8'h00 : window[HIST_AW'(produced - LEN_W'(off))];
          done = put_byte(v, bad);
        end
        next_token(done);
      end
      default: phase = STREAM_DONE;
    endcase
    for (int i = 0; i < run_len; i++) begin
      if (i == run_len - 1) run_buf[i].run_last = 1'b1;
      expected_out.push_back(run_buf[i]);
    end
  endtask

  // Compare results first, then decode the request of the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_stream();
      expected_out.delete();
      errors       = 0;
      results_seen = 0;
      bad_seen     = 0;
      pending      = 0;
    end else begin
      if (dst_valid && dst_ready) begin
        results_seen++;
        if (dst_item.bad_reference === 1'b1) bad_seen++;
        if (expected_out.size() == 0) begin
          $error("unexpected result: out_byte %0h", dst_item.out_byte);
          errors++;
        end else begin
          head = expected_out.pop_front();
          if (dst_item.out_byte !== head.out_byte) begin
            $error("out_byte: expected %0h, got %0h", head.out_byte, dst_item.out_byte);
            errors++;
          end
          if (dst_item.run_last !== head.run_last) begin
            $error("run_last: expected %0b, got %0b", head.run_last, dst_item.run_last);
            errors++;
          end
          if (dst_item.data_end !== head.data_end) begin
            $error("data_end: expected %0b, got %0b", head.data_end, dst_item.data_end);
            errors++;
          end
          if (dst_item.bad_reference !== head.bad_reference) begin
            $error("bad_reference: expected %0b, got %0b",
                   head.bad_reference, dst_item.bad_reference);
            errors++;
          end
        end
      end
      if (src_valid && src_ready) decode_request(src_item.in_byte, src_item.stream_start);
      pending = expected_out.size();
    end
  end

endmodule

// ===== bench/lzss_stream_decompressor_test.sv =====
// Testbench top for the LZSS stream decompressor: clock, reset, stimulus and verdict.
module lzss_stream_decompressor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lzss_pkg::*;

  localparam int RANDOM_ITEMS = 145;
  localparam int IDLE_PCT     = 26;
  localparam int CALM_FROM    = 70;
  localparam int CALM_TO      = 120;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  in_item_t  src_item  = '0;
  logic      dst_valid;
  logic      dst_ready = 1'b0;
  out_item_t dst_item;
  logic      calm      = 1'b0;

  int bytes_sent = 0;
  int noise_sent = 0;
  int streams    = 0;
  int errors, pending, results_seen, bad_seen;

  initial begin
    forever #1 clk = ~clk;
  end

  lzss_stream_decompressor i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item)
  );

  lzss_stream_decompressor_check i_check (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_ready    (src_ready),
    .src_item     (src_item),
    .dst_valid    (dst_valid),
    .dst_ready    (dst_ready),
    .dst_item     (dst_item),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .bad_seen     (bad_seen)
  );

  // Stall the result side at random, except in the calm stretch
  initial begin
    forever begin
      @(posedge clk);
      dst_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one request, with random idle cycles ahead of it; hold until accepted
  task automatic send_byte(input logic [7:0] b, input logic start);
    logic quiet;
    // Run without idling on either side through a fixed stretch of the stream
    quiet = (bytes_sent >= CALM_FROM) && (bytes_sent < CALM_TO);
    calm <= quiet;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= '{in_byte: b, stream_start: start};
    do @(posedge clk); while (!src_ready);
    bytes_sent++;
  endtask

  // Send one stream with random content, sometimes abandoned early; matches may reach before its start
  task automatic random_stream(input int budget);
    int unsigned want;
    int unsigned made;
    int unsigned hdr;
    int unsigned room;
    int          sel;
    logic        first;
    logic [7:0]  flags;
    logic [3:0]  len_code;
    logic [11:0] off_code;
    sel = $urandom_range(99);
    if (sel < 6) want = 0;
    else if (sel < 20) want = $urandom_range(3000, 129);
    else want = $urandom_range(90, 1);
    streams++;
    hdr   = want;
    first = 1'b1;
    do begin
      send_byte(8'(hdr % 128) | ((hdr > 127) ? 8'h80 : 8'h00), first);
      first = 1'b0;
      hdr   = hdr >> 7;
    end while (hdr != 0);
    made = 0;
    while (made < want && bytes_sent - noise_sent < budget) begin
      flags = 8'($urandom_range(255));
      send_byte(flags, 1'b0);
      for (int t = 0; t < 8 && made < want; t++) begin
        // Drop the stream now and then so the next one starts mid-way
        if ($urandom_range(39) == 0) return;
        if (flags[7-t]) begin
          send_byte(8'($urandom_range(255)), 1'b0);
          made++;
        end else begin
          len_code = 4'($urandom_range(15));
          if (made >= 3 && $urandom_range(99) < 85) begin
            room     = (made - 3 > 4095) ? 4095 : made - 3;
            off_code = 12'($urandom_range(room));
          end else begin
            off_code = 12'($urandom_range(4095));
          end
          send_byte({len_code, off_code[11:8]}, 1'b0);
          send_byte(off_code[7:0], 1'b0);
          made += int'(len_code) + 3;
        end
      end
    end
    // Trail a few bytes that the block must ignore
    if (made >= want && $urandom_range(2) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        send_byte(8'($urandom_range(255)), 1'b0);
        noise_sent++;
      end
    end
  endtask

  initial begin
    int budget;
    int base;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // No stream start after reset; early references, a valid copy cut at the end
    send_byte(8'h07, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h5A, 1'b0);
    // Zero declared length: the following byte is dropped
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    // Overlong header, then a longest match with the largest offset
    send_byte(8'hFF, 1'b1);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Restart in the middle of the token phase
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hA5, 1'b0);

    base   = bytes_sent - noise_sent;
    budget = base + RANDOM_ITEMS;
    while (bytes_sent - noise_sent < budget) begin
      random_stream(budget);
    end
    src_valid <= 1'b0;
    calm      <= 1'b0;

    // Drain the outstanding results, then watch for strays
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d compressed bytes, %0d random streams and %0d output bytes,",
             bytes_sent, streams, results_seen);
    $display("  %0d of the output bytes reached before the start of their stream", bad_seen);
    if (errors == 0 && pending == 0) begin
      $display("lzss_stream_decompressor_test: done, clean");
    end else begin
      $display("lzss_stream_decompressor_test: done, errors");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #400us;
    $display("lzss_stream_decompressor_test: done, errors");
    $finish;
  end

endmodule
